>>> rtl/cppo_pkg.sv
// ----------------------------------------------------------------------------
// cppo_pkg
// Shared types and constants for the capsule pair overlap penalty block.
// ----------------------------------------------------------------------------
package cppo_pkg;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_A,
		S_RD_B,
		S_CAP_B,
		S_MUL,
		S_MUL_WAIT,
		S_DIV,
		S_DIV_WAIT,
		S_SQRT,
		S_SQRT_WAIT,
		S_DONE
	} state_t;

	typedef enum logic [5:0] {
		ST_PD0_X, ST_PD0_Y, ST_PD0_Z,
		ST_PD1_X, ST_PD1_Y, ST_PD1_Z,
		ST_D00_X, ST_D00_Y, ST_D00_Z,
		ST_D11_X, ST_D11_Y, ST_D11_Z,
		ST_D01_X, ST_D01_Y, ST_D01_Z,
		ST_P1_NA, ST_P1_NB, ST_P1_DA, ST_P1_DB,
		ST_P2,
		ST_P3,
		ST_EX_A, ST_EX_B, ST_EY_A, ST_EY_B, ST_EZ_A, ST_EZ_B,
		ST_SQ_X, ST_SQ_Y, ST_SQ_Z,
		ST_RS_A, ST_RE_A, ST_RS_B, ST_RE_B,
		ST_PEN,
		ST_WGT
	} step_t;

	typedef struct packed {
		logic  accept;
		logic  rd_b;
		logic  cap_a;
		logic  cap_b;
		logic  mul_start;
		logic  mul_post;
		logic  div_start;
		logic  div_b;
		logic  sqrt_start;
		logic  load_out;
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} stat_t;

	localparam logic        REG_PENALTY_WEIGHT = 1'b0;
	localparam logic [31:0] WEIGHT_RESET       = 32'd65536;
	localparam logic [16:0] ONE_Q16            = 17'd65536;
	localparam logic [62:0] SAT63              = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam int          DIV_STEPS          = 16;
	localparam int          SQRT_STEPS         = 34;

endpackage

>>> rtl/cppo_ram.sv
// ----------------------------------------------------------------------------
// cppo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cppo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/cppo_mul.sv
// ----------------------------------------------------------------------------
// cppo_mul
// Signed 64x64 multiplier, one 64x16 partial product per cycle.
// ----------------------------------------------------------------------------
module cppo_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [63:0]   a,
	input  logic signed [63:0]   b,
	output logic signed [127:0]  prod,
	output logic                 done
);

	logic [63:0]  ua_q, ub_q;
	logic [127:0] acc_q;
	logic         neg_q;
	logic [1:0]   cnt_q;
	logic         busy_q, fin_q, done_q;
	logic [127:0] prod_q;
	logic [79:0]  partial;
	logic [127:0] acc_n;

	assign partial = ua_q * ub_q[15:0];
	assign acc_n   = acc_q + (128'(partial) << {cnt_q, 4'b0000});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= a[63] ? (~a + 64'd1) : a;
			ub_q  <= b[63] ? (~b + 64'd1) : b;
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_n;
			ub_q  <= {16'd0, ub_q[63:16]};
		end
		if (fin_q) begin
			prod_q <= neg_q ? (~acc_q + 128'd1) : acc_q;
		end
	end

	assign prod = signed'(prod_q);
	assign done = done_q;

endmodule

>>> rtl/cppo_ctrl.sv
// ----------------------------------------------------------------------------
// cppo_ctrl
// Sequencer: fetches both capsules, steps the datapath through the products,
// the three clamped divisions and the square root, then loads the result.
// ----------------------------------------------------------------------------
module cppo_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tuser,
	input  cppo_pkg::stat_t st,
	output logic            s_tready,
	output cppo_pkg::cmd_t  cmd
);
	import cppo_pkg::*;

	state_t state_q, state_d;
	step_t  step_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (s_tvalid && s_tuser) state_d = S_RD_A;
			S_RD_A: state_d = S_RD_B;
			S_RD_B: state_d = S_CAP_B;
			S_CAP_B: state_d = S_MUL;
			S_MUL: state_d = S_MUL_WAIT;
			S_MUL_WAIT: if (st.mul_done) begin
				unique case (step_q) inside
					ST_P1_DB, ST_P2, ST_P3: state_d = S_DIV;
					ST_SQ_Z: state_d = S_SQRT;
					ST_WGT: state_d = S_DONE;
					default: state_d = S_MUL;
				endcase
			end
			S_DIV: state_d = S_DIV_WAIT;
			S_DIV_WAIT: if (st.div_done) state_d = S_MUL;
			S_SQRT: state_d = S_SQRT_WAIT;
			S_SQRT_WAIT: if (st.sqrt_done) state_d = S_MUL;
			S_DONE: if (st.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= ST_PD0_X;
		end else begin
			state_q <= state_d;
			if (state_q == S_CAP_B) begin
				step_q <= ST_PD0_X;
			end else if (state_d == S_MUL && state_q != S_MUL) begin
				step_q <= step_t'(6'(step_q) + 6'd1);
			end
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.step       = step_q;
		s_tready       = (state_q == S_IDLE);
		cmd.accept     = (state_q == S_IDLE) && s_tvalid;
		cmd.rd_b       = (state_q == S_RD_B);
		cmd.cap_a      = (state_q == S_RD_B);
		cmd.cap_b      = (state_q == S_CAP_B);
		cmd.mul_start  = (state_q == S_MUL);
		cmd.mul_post   = (state_q == S_MUL_WAIT) && st.mul_done;
		cmd.div_start  = (state_q == S_DIV);
		cmd.div_b      = (step_q == ST_P2);
		cmd.sqrt_start = (state_q == S_SQRT);
		cmd.load_out   = (state_q == S_DONE) && st.out_free;
	end

	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		st.mul_done |-> state_q == S_MUL_WAIT) else $error("multiplier done out of sequence");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> state_q == S_DIV_WAIT) else $error("divider done out of sequence");
	a_sqrt_done: assert property (@(posedge clk) disable iff (!arst_n)
		st.sqrt_done |-> state_q == S_SQRT_WAIT) else $error("root done out of sequence");
	a_done_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> step_q == ST_WGT) else $error("result loaded before last step");

endmodule

>>> rtl/cppo_dp.sv
// ----------------------------------------------------------------------------
// cppo_dp
// Datapath: capsule table, operand selection, shared multiplier, clamped
// divider, integer square root, running total and output word register.
// ----------------------------------------------------------------------------
module cppo_dp #(
	parameter int MAX_CAPSULES = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cppo_pkg::cmd_t  cmd,
	output cppo_pkg::stat_t st,
	input  logic [255:0]    s_tdata,
	input  logic            s_tuser,
	input  logic            s_tlast,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [215:0]    m_tdata,
	output logic            m_tlast,
	input  logic            cfg_we,
	input  logic [31:0]     cfg_wdata,
	output logic [31:0]     weight
);
	import cppo_pkg::*;

	localparam int AW     = $clog2(MAX_CAPSULES);
	localparam int WORD_W = 240;

	function automatic logic [AW-1:0] slot_of(input logic [5:0] v);
		logic [AW-1:0] r;
		r = '0;
		for (int i = 0; i < 64; i++) begin
			if (v == 6'(i)) r = AW'(i % MAX_CAPSULES);
		end
		return r;
	endfunction

	logic [5:0]          idx_a_q, idx_b_q;
	logic                last_q;
	logic [WORD_W-1:0]   rdata;
	logic signed [31:0]  pa_q [3], da_q [3], pb_q [3], db_q [3];
	logic [23:0]         rs_a_q, re_a_q, rs_b_q, re_b_q;
	logic signed [32:0]  pv [3];
	logic signed [50:0]  pd0_q, pd1_q, d00_q, d11_q, d01_q;
	logic signed [127:0] tmp_q, num_q, den_q;
	logic [16:0]         ta_q, tb_q;
	logic signed [34:0]  ex_q [3];
	logic [67:0]         sq_q;
	logic [41:0]         rad_q;
	logic [33:0]         root_q;
	logic signed [34:0]  ovl;
	logic [49:0]         pen_q;
	logic [62:0]         total_q, sum_q, term, total_n;
	logic [63:0]         sum64;
	logic [31:0]         weight_q;
	logic signed [63:0]  ma, mb;
	logic signed [127:0] prod, fl;
	logic                mul_done;
	logic [215:0]        out_data_q;
	logic                out_last_q, out_valid_q;

	cppo_ram #(.WIDTH(WORD_W), .DEPTH(MAX_CAPSULES)) u_table (
		.clk   (clk),
		.we    (cmd.accept && !s_tuser),
		.waddr (slot_of(s_tdata[5:0])),
		.wdata (s_tdata[251:12]),
		.raddr (cmd.rd_b ? slot_of(idx_b_q) : slot_of(idx_a_q)),
		.rdata (rdata)
	);

	cppo_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (ma),
		.b      (mb),
		.prod   (prod),
		.done   (mul_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_a_q <= s_tdata[5:0];
			idx_b_q <= s_tdata[11:6];
			last_q  <= s_tlast;
		end
		if (cmd.cap_a) begin
			for (int i = 0; i < 3; i++) begin
				pa_q[i] <= rdata[32*i +: 32];
				da_q[i] <= rdata[96 + 32*i +: 32];
			end
			rs_a_q <= rdata[215:192];
			re_a_q <= rdata[239:216];
		end
		if (cmd.cap_b) begin
			for (int i = 0; i < 3; i++) begin
				pb_q[i] <= rdata[32*i +: 32];
				db_q[i] <= rdata[96 + 32*i +: 32];
			end
			rs_b_q <= rdata[215:192];
			re_b_q <= rdata[239:216];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pv[i] = 33'(pb_q[i]) - 33'(pa_q[i]);
		end
	end

	assign ovl = signed'({9'd0, rad_q[41:16]}) - signed'({1'b0, root_q});

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.step)
			ST_PD0_X: begin ma = 64'(pv[0]); mb = 64'(da_q[0]); end
			ST_PD0_Y: begin ma = 64'(pv[1]); mb = 64'(da_q[1]); end
			ST_PD0_Z: begin ma = 64'(pv[2]); mb = 64'(da_q[2]); end
			ST_PD1_X: begin ma = 64'(pv[0]); mb = 64'(db_q[0]); end
			ST_PD1_Y: begin ma = 64'(pv[1]); mb = 64'(db_q[1]); end
			ST_PD1_Z: begin ma = 64'(pv[2]); mb = 64'(db_q[2]); end
			ST_D00_X: begin ma = 64'(da_q[0]); mb = 64'(da_q[0]); end
			ST_D00_Y: begin ma = 64'(da_q[1]); mb = 64'(da_q[1]); end
			ST_D00_Z: begin ma = 64'(da_q[2]); mb = 64'(da_q[2]); end
			ST_D11_X: begin ma = 64'(db_q[0]); mb = 64'(db_q[0]); end
			ST_D11_Y: begin ma = 64'(db_q[1]); mb = 64'(db_q[1]); end
			ST_D11_Z: begin ma = 64'(db_q[2]); mb = 64'(db_q[2]); end
			ST_D01_X: begin ma = 64'(da_q[0]); mb = 64'(db_q[0]); end
			ST_D01_Y: begin ma = 64'(da_q[1]); mb = 64'(db_q[1]); end
			ST_D01_Z: begin ma = 64'(da_q[2]); mb = 64'(db_q[2]); end
			ST_P1_NA: begin ma = 64'(pd0_q); mb = 64'(d11_q); end
			ST_P1_NB: begin ma = 64'(pd1_q); mb = 64'(d01_q); end
			ST_P1_DA: begin ma = 64'(d00_q); mb = 64'(d11_q); end
			ST_P1_DB: begin ma = 64'(d01_q); mb = 64'(d01_q); end
			ST_P2:    begin ma = 64'(ta_q); mb = 64'(d01_q); end
			ST_P3:    begin ma = 64'(tb_q); mb = 64'(d01_q); end
			ST_EX_A:  begin ma = 64'(ta_q); mb = 64'(da_q[0]); end
			ST_EX_B:  begin ma = 64'(tb_q); mb = 64'(db_q[0]); end
			ST_EY_A:  begin ma = 64'(ta_q); mb = 64'(da_q[1]); end
			ST_EY_B:  begin ma = 64'(tb_q); mb = 64'(db_q[1]); end
			ST_EZ_A:  begin ma = 64'(ta_q); mb = 64'(da_q[2]); end
			ST_EZ_B:  begin ma = 64'(tb_q); mb = 64'(db_q[2]); end
			ST_SQ_X:  begin ma = 64'(ex_q[0]); mb = 64'(ex_q[0]); end
			ST_SQ_Y:  begin ma = 64'(ex_q[1]); mb = 64'(ex_q[1]); end
			ST_SQ_Z:  begin ma = 64'(ex_q[2]); mb = 64'(ex_q[2]); end
			ST_RS_A:  begin ma = 64'(rs_a_q); mb = 64'(17'(ONE_Q16 - ta_q)); end
			ST_RE_A:  begin ma = 64'(re_a_q); mb = 64'(ta_q); end
			ST_RS_B:  begin ma = 64'(rs_b_q); mb = 64'(17'(ONE_Q16 - tb_q)); end
			ST_RE_B:  begin ma = 64'(re_b_q); mb = 64'(tb_q); end
			ST_PEN:   begin ma = 64'(ovl); mb = 64'(ovl); end
			ST_WGT:   begin ma = 64'(pen_q); mb = 64'(weight_q); end
			default:  begin ma = '0; mb = '0; end
		endcase
	end

	assign fl      = prod >>> 16;
	assign term    = (|prod[127:79]) ? SAT63 : prod[78:16];
	assign sum64   = {1'b0, sum_q} + {1'b0, term};
	assign total_n = sum64[63] ? SAT63 : sum64[62:0];

	always_ff @(posedge clk) begin
		if (cmd.mul_post) begin
			case (cmd.step) inside
				ST_PD0_X: pd0_q <= 51'(fl);
				ST_PD0_Y, ST_PD0_Z: pd0_q <= pd0_q + 51'(fl);
				ST_PD1_X: pd1_q <= 51'(fl);
				ST_PD1_Y, ST_PD1_Z: pd1_q <= pd1_q + 51'(fl);
				ST_D00_X: d00_q <= 51'(fl);
				ST_D00_Y, ST_D00_Z: d00_q <= d00_q + 51'(fl);
				ST_D11_X: d11_q <= 51'(fl);
				ST_D11_Y, ST_D11_Z: d11_q <= d11_q + 51'(fl);
				ST_D01_X: d01_q <= 51'(fl);
				ST_D01_Y, ST_D01_Z: d01_q <= d01_q + 51'(fl);
				ST_P1_NA, ST_P1_DA: tmp_q <= prod;
				ST_P1_NB: num_q <= tmp_q - prod;
				ST_P1_DB: den_q <= tmp_q - prod;
				ST_P2: begin
					num_q <= prod - (128'(pd1_q) <<< 16);
					den_q <= 128'(d11_q) <<< 16;
				end
				ST_P3: begin
					num_q <= prod + (128'(pd0_q) <<< 16);
					den_q <= 128'(d00_q) <<< 16;
				end
				ST_EX_A: ex_q[0] <= 35'(pa_q[0]) + 35'(fl);
				ST_EX_B: ex_q[0] <= ex_q[0] - 35'(pb_q[0]) - 35'(fl);
				ST_EY_A: ex_q[1] <= 35'(pa_q[1]) + 35'(fl);
				ST_EY_B: ex_q[1] <= ex_q[1] - 35'(pb_q[1]) - 35'(fl);
				ST_EZ_A: ex_q[2] <= 35'(pa_q[2]) + 35'(fl);
				ST_EZ_B: ex_q[2] <= ex_q[2] - 35'(pb_q[2]) - 35'(fl);
				ST_SQ_X: sq_q <= prod[67:0];
				ST_SQ_Y, ST_SQ_Z: sq_q <= sq_q + prod[67:0];
				ST_RS_A: rad_q <= prod[41:0];
				ST_RE_A, ST_RS_B, ST_RE_B: rad_q <= rad_q + prod[41:0];
				ST_PEN: pen_q <= (ovl > 35'sd0) ? prod[49:0] : '0;
				ST_WGT: total_q <= total_n;
				default: ;
			endcase
		end
	end

	// clamped division, restoring, one quotient bit a cycle
	logic         div_busy_q, div_done_q, div_b_q;
	logic [3:0]   div_cnt_q;
	logic [127:0] rem_q, rem_sh, rem_nx;
	logic [15:0]  quo_q, quo_nx;
	logic         div_spec, div_ge;
	logic [16:0]  div_keep, div_val;

	always_comb begin
		div_keep = cmd.div_b ? tb_q : ta_q;
		div_spec = 1'b1;
		div_val  = div_keep;
		if (den_q <= 128'sd0) begin
			div_val = div_keep;
		end else if (num_q <= 128'sd0) begin
			div_val = '0;
		end else if (num_q >= den_q) begin
			div_val = ONE_Q16;
		end else begin
			div_spec = 1'b0;
		end
		rem_sh = {rem_q[126:0], 1'b0};
		div_ge = rem_sh >= den_q;
		rem_nx = div_ge ? (rem_sh - den_q) : rem_sh;
		quo_nx = {quo_q[14:0], div_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			div_done_q <= 1'b0;
			if (cmd.div_start) begin
				if (div_spec) begin
					div_done_q <= 1'b1;
				end else begin
					div_busy_q <= 1'b1;
					div_cnt_q  <= '0;
				end
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + 4'd1;
				if (div_cnt_q == 4'(DIV_STEPS - 1)) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			ta_q <= '0;
			tb_q <= '0;
		end else if (cmd.div_start) begin
			div_b_q <= cmd.div_b;
			rem_q   <= num_q;
			quo_q   <= '0;
			if (div_spec) begin
				if (cmd.div_b) tb_q <= div_val;
				else ta_q <= div_val;
			end
		end else if (div_busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
			if (div_cnt_q == 4'(DIV_STEPS - 1)) begin
				if (div_b_q) tb_q <= {1'b0, quo_nx};
				else ta_q <= {1'b0, quo_nx};
			end
		end
	end

	// integer square root, one result bit a cycle
	logic        sq_busy_q, sq_done_q;
	logic [5:0]  sq_cnt_q;
	logic [67:0] sh_q;
	logic [37:0] srem_q, srem_n, trial;
	logic        sq_ge;

	always_comb begin
		srem_n = {srem_q[35:0], sh_q[67:66]};
		trial  = {2'b00, root_q, 2'b01};
		sq_ge  = srem_n >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_busy_q <= 1'b0;
			sq_done_q <= 1'b0;
			sq_cnt_q  <= '0;
		end else begin
			sq_done_q <= 1'b0;
			if (cmd.sqrt_start) begin
				sq_busy_q <= 1'b1;
				sq_cnt_q  <= '0;
			end else if (sq_busy_q) begin
				sq_cnt_q <= sq_cnt_q + 6'd1;
				if (sq_cnt_q == 6'(SQRT_STEPS - 1)) begin
					sq_busy_q <= 1'b0;
					sq_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sh_q   <= sq_q;
			root_q <= '0;
			srem_q <= '0;
		end else if (sq_busy_q) begin
			sh_q   <= {sh_q[65:0], 2'b00};
			srem_q <= sq_ge ? (srem_n - trial) : srem_n;
			root_q <= {root_q[32:0], sq_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			weight_q    <= WEIGHT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) weight_q <= cfg_wdata;
			if (cmd.load_out) begin
				sum_q       <= last_q ? '0 : total_q;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= {total_q, pen_q, ovl, root_q, tb_q, ta_q};
			out_last_q <= last_q;
		end
	end

	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_data_q;
	assign m_tlast      = out_last_q;
	assign weight       = weight_q;
	assign st.mul_done  = mul_done;
	assign st.div_done  = div_done_q;
	assign st.sqrt_done = sq_done_q;
	assign st.out_free  = !out_valid_q || m_tready;

endmodule

>>> rtl/capsule_pair_overlap_penalty.sv
// ----------------------------------------------------------------------------
// capsule_pair_overlap_penalty
// Tapered capsule table with pairwise closest-point distance, overlap,
// squared penalty and saturating weighted running total.
//
//   port group   direction  carries
//   s_*          in         capsule write (tuser=0) or pair query (tuser=1)
//   m_*          out        one result word per query, tlast echoes last
//   p*           in/out     penalty_weight register at byte address 0
//
// A query runs 36 products on the shared 64x16-per-cycle multiplier, three
// clamped divisions (the restoring loop runs only when the result does not
// clamp) and an integer square root. One query is in work at a time; a
// finished result waits in the output register while the next word is
// taken. A stalled result holds the next query at its final step.
// Reset clears the total and restores the weight; table contents stay
// undefined until written.
// ----------------------------------------------------------------------------
module capsule_pair_overlap_penalty #(
	parameter int MAX_CAPSULES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// index, other_index, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
	// radius_start, radius_end, zero fill
	input  logic [255:0] s_tdata,
	// func
	input  logic         s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// param_a, param_b, distance, overlap, penalty, weighted_total
	output logic [215:0] m_tdata,
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import cppo_pkg::*;

	cmd_t        cmd;
	stat_t       st;
	logic        cfg_we;
	logic [31:0] weight;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_PENALTY_WEIGHT);
	assign prdata = (paddr[2] == REG_PENALTY_WEIGHT) ? weight : '0;

	cppo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.st       (st),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	cppo_dp #(.MAX_CAPSULES(MAX_CAPSULES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (pwdata),
		.weight    (weight)
	);

endmodule
